FILE: rtl/ssbst_pkg.sv
//------------------------------------------------------------------------------
// ssbst_pkg
// Shared types and constants for the record table with Shell sort and search.
//------------------------------------------------------------------------------
`default_nettype none
package ssbst_pkg;

	localparam int DefTableDepth = 128;
	localparam int DefTagWidth   = 16;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_SORT   = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] item_key;
		logic [15:0]        item_tag;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         position;
		logic signed [31:0] found_key;
		logic [15:0]        found_tag;
	} out_beat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GAP,      // start a gap pass
		S_IRD,      // read element i
		S_IHOLD,    // capture element i
		S_JRD,      // read element j-gap
		S_JCMP,     // compare and shift
		S_JPUT,     // place held element at j
		S_SRD,      // read midpoint
		S_SCMP,     // compare midpoint
		S_OUT       // result waits in output register
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/ssbst_ram.sv
//------------------------------------------------------------------------------
// ssbst_ram
// Generic single-port synchronous RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module ssbst_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/shell_sort_binary_search_table.sv
//------------------------------------------------------------------------------
// shell_sort_binary_search_table
// Record table: append, in-place Shell sort by key, binary search, clear.
//------------------------------------------------------------------------------
// Usage:
//   Input channel "in" (valid/stall) carries one beat per command: append,
//   sort, search or clear. Output channel "out" (valid/stall) returns exactly
//   one result beat per command.
//   Records live in one RAM of key and tag, one access per cycle.
//   Append and clear load the result register at the accepting edge and
//   offer the result beat on the next cycle. A search reads and compares one
//   midpoint per probe, up to log2(depth)+1 probes, and reports a miss once
//   the range is empty. A sort halves the gap for each pass; for each element
//   it reads and holds it, then reads and compares keys at gap spacing,
//   shifting larger ones up, and places the held element, all bounded by
//   the single RAM port. Each command ends with the result handoff.
//   One command is in work at a time; the next is taken once the result has
//   been loaded into the output register and handed on.
//   Reset empties the table; stored entries are not cleared and need none.
//   When the receiver stalls, the result beat holds and no input is taken.
//------------------------------------------------------------------------------
`default_nettype none
module shell_sort_binary_search_table
	import ssbst_pkg::*;
#(
	parameter int TableDepth = DefTableDepth,
	parameter int TagWidth   = DefTagWidth
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_beat_t      out_data
);
	localparam int AW = $clog2(TableDepth);
	localparam int CW = AW + 1;
	localparam int RW = 32 + TagWidth;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, gap_q, i_q, j_q;
	logic signed [CW:0] lo_q, hi_q;
	logic signed [31:0] hkey_q, skey_q;
	logic [TagWidth-1:0] htag_q;
	out_beat_t res_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [RW-1:0] wdata, rdata;
	logic signed [31:0] rkey;
	logic [TagWidth-1:0] rtag;
	logic signed [CW:0] mid;
	logic [CW-1:0] jg;
	logic accept;

	assign rkey = rdata[RW-1:TagWidth];
	assign rtag = rdata[TagWidth-1:0];
	assign mid  = (lo_q + hi_q) >>> 1;
	assign jg   = j_q - gap_q;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	ssbst_ram #(.Width(RW), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action_t'(in_data.action))
						ACT_SORT:   state_d = S_GAP;
						ACT_SEARCH: state_d = S_SRD;
						default:    state_d = S_OUT;
					endcase
				end
			end
			S_GAP:   state_d = ((gap_q >> 1) == '0) ? S_OUT : S_IRD;
			S_IRD:   state_d = (i_q < count_q) ? S_IHOLD : S_GAP;
			S_IHOLD: state_d = (i_q >= gap_q) ? S_JRD : S_JPUT;
			S_JRD:   state_d = S_JCMP;
			S_JCMP:  state_d = (rkey > hkey_q) ? ((jg >= gap_q) ? S_JRD : S_JPUT)
				: S_JPUT;
			S_JPUT:  state_d = S_IRD;
			S_SRD:   state_d = (lo_q <= hi_q) ? S_SCMP : S_OUT;
			S_SCMP:  state_d = (rkey == skey_q) ? S_OUT : S_SRD;
			S_OUT:   state_d = out_stall ? S_OUT : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port
	always_comb begin
		we    = 1'b0;
		addr  = '0;
		wdata = {hkey_q, htag_q};
		unique case (state_q)
			S_IDLE: begin
				addr  = count_q[AW-1:0];
				wdata = {in_data.item_key, TagWidth'(in_data.item_tag)};
				we    = accept && (action_t'(in_data.action) == ACT_APPEND)
					&& (count_q < CW'(TableDepth));
			end
			S_IRD:  addr = i_q[AW-1:0];
			S_JRD:  addr = jg[AW-1:0];
			S_JCMP: begin
				addr  = j_q[AW-1:0];
				wdata = rdata;
				we    = (rkey > hkey_q);
			end
			S_JPUT: begin
				addr = j_q[AW-1:0];
				we   = 1'b1;
			end
			S_SRD:  addr = mid[AW-1:0];
			default: addr = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && action_t'(in_data.action) == ACT_APPEND
				&& count_q < CW'(TableDepth)) begin
				count_q <= count_q + 1'b1;
			end
			if (accept && action_t'(in_data.action) == ACT_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				gap_q  <= count_q;
				skey_q <= in_data.item_key;
				lo_q   <= '0;
				hi_q   <= (CW+1)'($signed({1'b0, count_q}) - 1);
				if (action_t'(in_data.action) == ACT_APPEND && count_q >= CW'(TableDepth))
					res_q <= '{status: ST_FULL, default: '0};
				else if (action_t'(in_data.action) == ACT_SEARCH)
					res_q <= '{status: ST_MISS, default: '0};
				else
					res_q <= '0;
			end
			S_GAP: begin
				gap_q <= gap_q >> 1;
				i_q   <= gap_q >> 1;
			end
			S_IHOLD: begin
				hkey_q <= rkey;
				htag_q <= rtag;
				j_q    <= i_q;
			end
			S_JCMP: begin
				if (rkey > hkey_q) j_q <= jg;
			end
			S_JPUT: i_q <= i_q + 1'b1;
			S_SRD: i_q <= mid[CW-1:0];
			S_SCMP: begin
				if (rkey == skey_q) begin
					res_q.status    <= ST_OK;
					res_q.position  <= 7'(i_q);
					res_q.found_key <= rkey;
					res_q.found_tag <= 16'(rtag);
				end else if (skey_q < rkey) begin
					hi_q <= (CW+1)'($signed({1'b0, i_q}) - 1);
				end else begin
					lo_q <= (CW+1)'($signed({1'b0, i_q}) + 1);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
